// ----- src/swmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and constants for the stack with middle delete.
// ----------------------------------------------------------------------------
package swmd_pkg;

  // Fixed field widths of the channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;

  // Operation codes; the fourth code is a no-op
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DEL_MID = 2'd2
  } op_e;

endpackage

// ----- src/swmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_in_if / swmd_out_if
// Valid/ready channels carrying operations in and results out.
// ----------------------------------------------------------------------------

// Operation channel
interface swmd_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [swmd_pkg::OP_W-1:0]                 op;
  logic signed [swmd_pkg::VALUE_W-1:0]       push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

// Result channel; the count width follows the stack depth
interface swmd_out_if #(
  parameter int unsigned COUNT_W = 9
);
  logic                                      valid;
  logic                                      ready;
  logic signed [swmd_pkg::VALUE_W-1:0]       removed_value;
  logic                                      removed_valid;
  logic                                      empty_error;
  logic                                      full_error;
  logic signed [swmd_pkg::VALUE_W-1:0]       top_value;
  logic signed [swmd_pkg::VALUE_W-1:0]       mid_value;
  logic [COUNT_W-1:0]                        entry_total;

  modport source (
    output valid, output removed_value, output removed_valid, output empty_error,
    output full_error, output top_value, output mid_value, output entry_total,
    input ready
  );
  modport sink (
    input valid, input removed_value, input removed_valid, input empty_error,
    input full_error, input top_value, input mid_value, input entry_total,
    output ready
  );
endinterface

// ----- src/stack_with_middle_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_middle_delete
// Bounded stack kept as a doubly linked list in slot memories, tracking its
// middle entry so that it can be removed in constant time.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  -------  ---  -------------  ---------------------------------------------
//  in_i     in   valid / ready  op, push_value
//  out_o    out  valid / ready  removed_value, removed_valid, empty_error,
//                               full_error, top_value, mid_value, entry_total
//
// Each transaction steps through the idle, link and finish states: the accept
// in idle reads the link memory, the link state rewrites the links and reads
// the new top and middle values, the finish state loads the output register.
// No new operation is taken until the block is back in idle, as the link and
// value memories have registered reads.
// Memories need no clearing after reset: free slots come from a free list
// threaded through the value memory first, then from a fresh counter.
// A stalled output holds the block in its last cycle until the register frees.
// ----------------------------------------------------------------------------
module stack_with_middle_delete #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  swmd_in_if.sink           in_i,
  swmd_out_if.source        out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;              // slot pointer with null
  localparam int unsigned CW = $clog2(DEPTH + 1);   // entry count
  localparam int unsigned VW = (DATA_WIDTH > PW) ? DATA_WIDTH : PW;
  localparam int unsigned OW = swmd_pkg::VALUE_W;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LINK   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  typedef struct packed {
    logic [PW-1:0] down;
    logic [PW-1:0] up;
  } link_t;

  // Memories
  link_t           link_mem [DEPTH];
  logic [VW-1:0]   val_mem  [DEPTH];

  // Control state
  logic [1:0]      state_q, state_d;
  logic [CW-1:0]   held_q, held_d;
  logic [PW-1:0]   top_q, top_d;
  logic [PW-1:0]   mid_q, mid_d;
  logic [PW-1:0]   free_head_q, free_head_d;
  logic [CW-1:0]   fresh_q, fresh_d;
  logic [OW-1:0]   top_val_q, top_val_d;
  logic [OW-1:0]   mid_val_q, mid_val_d;
  logic            out_valid_q, out_valid_d;

  // Per-transaction working registers
  logic                  do_push_q, do_push_d;
  logic                  do_pop_q, do_pop_d;
  logic                  do_del_q, do_del_d;
  logic                  empty_err_q, empty_err_d;
  logic                  full_err_q, full_err_d;
  logic                  took_free_q, took_free_d;
  logic                  top_rd_q, top_rd_d;
  logic                  mid_rd_q, mid_rd_d;
  logic [PW-1:0]         slot_q, slot_d;
  logic [OW-1:0]         rem_q, rem_d;
  logic [DATA_WIDTH-1:0] pushv_q, pushv_d;

  // Output register
  logic [OW-1:0]   out_rem_q, out_top_q, out_mid_q;
  logic            out_rem_ok_q, out_empty_q, out_full_q;
  logic [CW-1:0]   out_cnt_q;

  // Memory ports
  logic            lr_en;
  link_t           lrd_a_q, lrd_b_q;
  logic            lw_dn, lw_up;
  logic [AW-1:0]   lw_addr;
  logic [PW-1:0]   lw_down, lw_upv;
  logic            vr_en;
  logic [AW-1:0]   vr_addr0, vr_addr1;
  logic [VW-1:0]   vrd0_q, vrd1_q;
  logic            vw_en;
  logic [AW-1:0]   vw_addr;
  logic [VW-1:0]   vw_data;

  logic                  in_accept, out_free, out_load;
  logic                  free_avail;
  logic [PW-1:0]         alloc_slot;
  logic [DATA_WIDTH-1:0] push_st;
  logic [OW-1:0]         push_out, vout0, vout1, top_fin, mid_fin;
  logic [PW-1:0]         new_mid;

  // Handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == ST_FINISH) && out_free;

  // Slot allocation: free list first, then never-used slots
  assign free_avail = (free_head_q != NIL);
  assign alloc_slot = free_avail ? free_head_q : PW'(fresh_q);

  // Value width conversions
  assign push_st  = DATA_WIDTH'(in_i.push_value);
  assign push_out = OW'(pushv_q);
  assign vout0    = OW'(vrd0_q[DATA_WIDTH-1:0]);
  assign vout1    = OW'(vrd1_q[DATA_WIDTH-1:0]);
  assign top_fin  = top_rd_q ? ((top_q == NIL) ? '0 : vout0) : top_val_q;
  assign mid_fin  = mid_rd_q ? ((mid_q == NIL) ? '0 : vout1) : mid_val_q;

  // Link memory: split write enables for the two link halves, read-first
  always_ff @(posedge clk_i) begin
    if (lw_dn) begin
      link_mem[lw_addr].down <= lw_down;
    end
    if (lw_up) begin
      link_mem[lw_addr].up <= lw_upv;
    end
    if (lr_en) begin
      lrd_a_q <= link_mem[top_q[AW-1:0]];
      lrd_b_q <= link_mem[mid_q[AW-1:0]];
    end
  end

  // Value memory: entry values, or next-free pointers for free slots
  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      val_mem[vw_addr] <= vw_data;
    end
    if (vr_en) begin
      vrd0_q <= val_mem[vr_addr0];
      vrd1_q <= val_mem[vr_addr1];
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    top_d       = top_q;
    mid_d       = mid_q;
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    top_val_d   = top_val_q;
    mid_val_d   = mid_val_q;
    do_push_d   = do_push_q;
    do_pop_d    = do_pop_q;
    do_del_d    = do_del_q;
    empty_err_d = empty_err_q;
    full_err_d  = full_err_q;
    took_free_d = took_free_q;
    top_rd_d    = top_rd_q;
    mid_rd_d    = mid_rd_q;
    slot_d      = slot_q;
    rem_d       = rem_q;
    pushv_d     = pushv_q;
    new_mid     = NIL;
    lr_en       = 1'b0;
    lw_dn       = 1'b0;
    lw_up       = 1'b0;
    lw_addr     = '0;
    lw_down     = '0;
    lw_upv      = '0;
    vr_en       = 1'b0;
    vr_addr0    = free_head_q[AW-1:0];
    vr_addr1    = '0;
    vw_en       = 1'b0;
    vw_addr     = '0;
    vw_data     = '0;

    unique case (state_q)
      // Accept: decode, read links of top and middle, write a pushed entry
      ST_IDLE: begin
        if (in_accept) begin
          do_push_d   = 1'b0;
          do_pop_d    = 1'b0;
          do_del_d    = 1'b0;
          empty_err_d = 1'b0;
          full_err_d  = 1'b0;
          took_free_d = 1'b0;
          rem_d       = '0;
          pushv_d     = push_st;
          lr_en       = 1'b1;
          vr_en       = 1'b1;
          state_d     = ST_LINK;
          unique case (swmd_pkg::op_e'(in_i.op))
            swmd_pkg::OP_PUSH: begin
              if (held_q == CW'(DEPTH)) begin
                full_err_d = 1'b1;
              end else begin
                do_push_d   = 1'b1;
                slot_d      = alloc_slot;
                took_free_d = free_avail;
                if (!free_avail) begin
                  fresh_d = fresh_q + CW'(1);
                end
                vw_en   = 1'b1;
                vw_addr = alloc_slot[AW-1:0];
                vw_data = VW'(push_st);
                lw_dn   = 1'b1;
                lw_up   = 1'b1;
                lw_addr = alloc_slot[AW-1:0];
                lw_down = top_q;
                lw_upv  = NIL;
              end
            end
            swmd_pkg::OP_POP: begin
              if (held_q == '0) begin
                empty_err_d = 1'b1;
              end else begin
                do_pop_d = 1'b1;
                rem_d    = top_val_q;
              end
            end
            swmd_pkg::OP_DEL_MID: begin
              if (held_q == '0) begin
                empty_err_d = 1'b1;
              end else begin
                do_del_d = 1'b1;
                rem_d    = mid_val_q;
              end
            end
            default: ;
          endcase
        end
      end

      // Relink, move top and middle, release the freed slot or pop the free list
      ST_LINK: begin
        state_d  = ST_FINISH;
        top_rd_d = 1'b0;
        mid_rd_d = 1'b0;
        vr_en    = 1'b1;
        if (do_push_q) begin
          if (top_q != NIL) begin
            lw_up   = 1'b1;
            lw_addr = top_q[AW-1:0];
            lw_upv  = slot_q;
          end
          if (took_free_q) begin
            free_head_d = vrd0_q[PW-1:0];
          end
          top_d     = slot_q;
          top_val_d = push_out;
          if (held_q == '0) begin
            mid_d     = slot_q;
            mid_val_d = push_out;
          end else if (!held_q[0]) begin
            mid_d    = lrd_b_q.up;
            vr_addr1 = lrd_b_q.up[AW-1:0];
            mid_rd_d = 1'b1;
          end
          held_d = held_q + CW'(1);
        end else if (do_pop_q) begin
          if (lrd_a_q.down != NIL) begin
            lw_up   = 1'b1;
            lw_addr = lrd_a_q.down[AW-1:0];
            lw_upv  = NIL;
          end
          top_d    = lrd_a_q.down;
          vr_addr0 = lrd_a_q.down[AW-1:0];
          top_rd_d = 1'b1;
          if (held_q[0]) begin
            mid_d    = lrd_b_q.down;
            vr_addr1 = lrd_b_q.down[AW-1:0];
            mid_rd_d = 1'b1;
          end
          vw_en       = 1'b1;
          vw_addr     = top_q[AW-1:0];
          vw_data     = VW'(free_head_q);
          free_head_d = top_q;
          held_d      = held_q - CW'(1);
        end else if (do_del_q) begin
          // down link of the entry above skips the middle
          if (lrd_b_q.up != NIL) begin
            lw_dn   = 1'b1;
            lw_addr = lrd_b_q.up[AW-1:0];
            lw_down = lrd_b_q.down;
          end
          if (top_q == mid_q) begin
            top_d    = lrd_b_q.down;
            vr_addr0 = lrd_b_q.down[AW-1:0];
            top_rd_d = 1'b1;
          end
          new_mid     = held_q[0] ? lrd_b_q.down : lrd_b_q.up;
          mid_d       = new_mid;
          vr_addr1    = new_mid[AW-1:0];
          mid_rd_d    = 1'b1;
          vw_en       = 1'b1;
          vw_addr     = mid_q[AW-1:0];
          vw_data     = VW'(free_head_q);
          free_head_d = mid_q;
          held_d      = held_q - CW'(1);
        end
      end

      // Pick up read values, finish a middle delete, load the result
      ST_FINISH: begin
        if (out_free) begin
          if (do_del_q && (lrd_b_q.down != NIL)) begin
            lw_up   = 1'b1;
            lw_addr = lrd_b_q.down[AW-1:0];
            lw_upv  = lrd_b_q.up;
          end
          top_val_d = top_fin;
          mid_val_d = mid_fin;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      top_q       <= NIL;
      mid_q       <= NIL;
      free_head_q <= NIL;
      fresh_q     <= '0;
      top_val_q   <= '0;
      mid_val_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      top_q       <= top_d;
      mid_q       <= mid_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      top_val_q   <= top_val_d;
      mid_val_q   <= mid_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the transaction in flight
  always_ff @(posedge clk_i) begin
    do_push_q   <= do_push_d;
    do_pop_q    <= do_pop_d;
    do_del_q    <= do_del_d;
    empty_err_q <= empty_err_d;
    full_err_q  <= full_err_d;
    took_free_q <= took_free_d;
    top_rd_q    <= top_rd_d;
    mid_rd_q    <= mid_rd_d;
    slot_q      <= slot_d;
    rem_q       <= rem_d;
    pushv_q     <= pushv_d;
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rem_q    <= rem_q;
      out_rem_ok_q <= do_pop_q || do_del_q;
      out_empty_q  <= empty_err_q;
      out_full_q   <= full_err_q;
      out_top_q    <= top_fin;
      out_mid_q    <= mid_fin;
      out_cnt_q    <= held_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = out_rem_q;
  assign out_o.removed_valid = out_rem_ok_q;
  assign out_o.empty_error   = out_empty_q;
  assign out_o.full_error    = out_full_q;
  assign out_o.top_value     = out_top_q;
  assign out_o.mid_value     = out_mid_q;
  assign out_o.entry_total   = out_cnt_q;

endmodule
